@@ hdl/ttm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ttm_pkg;

	localparam int TIME_W = 64;
	localparam int PER_W  = 32;
	localparam int WIN_W  = 27;
	localparam int ID_W   = 5;
	localparam int KIND_W = 3;

	// one hour in ms
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(60 * 60 * 1000);
	localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;

	// request kinds
	localparam logic [KIND_W-1:0] K_ADD     = 3'd0;
	localparam logic [KIND_W-1:0] K_CANCEL  = 3'd1;
	localparam logic [KIND_W-1:0] K_REFRESH = 3'd2;
	localparam logic [KIND_W-1:0] K_RESET   = 3'd3;
	localparam logic [KIND_W-1:0] K_QUERY   = 3'd4;
	localparam logic [KIND_W-1:0] K_EXPIRE  = 3'd5;

	// register index
	localparam logic REG_WINDOW = 1'b0;

	// status from the scan engine
	typedef struct packed {
		logic done;
		logic found;
		logic hit;
	} scan_stat_t;

endpackage
`default_nettype wire

@@ hdl/ttm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ttm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/ttm_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ttm_scan #(
	parameter int SLOTS = 32,
	parameter int AW    = 5
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [SLOTS-1:0]              mask,
	input  wire                          due_only,
	input  wire [ttm_pkg::TIME_W-1:0]    lim,
	input  wire [ttm_pkg::TIME_W-1:0]    rdata,
	output logic [AW-1:0]                raddr,
	output ttm_pkg::scan_stat_t          stat,
	output logic [AW-1:0]                cur_id,
	output logic [AW-1:0]                best_id,
	output logic [ttm_pkg::TIME_W-1:0]   best_exp
);
	import ttm_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	logic          busy_q;
	logic [AW-1:0] cnt_q;
	logic          chk_s1;
	logic [AW-1:0] id_s1;
	logic          done_q;
	logic          bv_q;
	logic [AW-1:0] bid_q;
	logic [TIME_W-1:0] bexp_q;
	logic          cand;

	// candidate: selected slot, optionally due by lim
	assign cand = chk_s1 && mask[id_s1] && (!due_only || (rdata <= lim));

	// one slot read per cycle, compared in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			chk_s1 <= 1'b0;
			id_s1  <= '0;
			done_q <= 1'b0;
			bv_q   <= 1'b0;
			bid_q  <= '0;
			bexp_q <= '0;
		end else begin
			chk_s1 <= busy_q;
			id_s1  <= cnt_q;
			done_q <= chk_s1 && (id_s1 == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				bv_q   <= 1'b0;
			end else begin
				if (busy_q) begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST) begin
						busy_q <= 1'b0;
					end
				end
				// strict compare keeps the lower slot on a tie
				if (cand && (!bv_q || (rdata < bexp_q))) begin
					bv_q   <= 1'b1;
					bid_q  <= id_s1;
					bexp_q <= rdata;
				end
			end
		end
	end

	assign raddr      = cnt_q;
	assign cur_id     = id_s1;
	assign best_id    = bid_q;
	assign best_exp   = bexp_q;
	assign stat.done  = done_q;
	assign stat.found = bv_q;
	assign stat.hit   = cand;
endmodule
`default_nettype wire

@@ hdl/timer_table_manager.sv @@
`timescale 1ns / 1ps
`default_nettype none
// cancel, refresh, add or reset without notice and unknown kinds need no slot scan;
// add and query with a slot scan and reset with a scan answer when the scan is done
// expire: the first scan marks the due timers and yields the earliest; each further
// result needs another scan, started once the output register is free; each scan
// reads the expiry memory one slot per cycle; one request at a time
// reset clears armed flags, last time and notice flag, and loads a one-hour window
module timer_table_manager #(
	parameter int TIMER_SLOTS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [2:0]                       paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// request channel
	input  wire                              req_valid,
	output logic                             req_ready,
	input  wire  [ttm_pkg::KIND_W-1:0]       kind,
	input  wire  [ttm_pkg::ID_W-1:0]         timer_id,
	input  wire  [ttm_pkg::PER_W-1:0]        period_ms,
	input  wire                              recurring,
	input  wire                              restart_now,
	input  wire  [ttm_pkg::TIME_W-1:0]       now_ms,
	// result channel
	output logic                             rsp_valid,
	input  wire                              rsp_ready,
	output logic [ttm_pkg::ID_W-1:0]         result_id,
	output logic                             ok,
	output logic                             front_notice,
	output logic [ttm_pkg::TIME_W-1:0]       time_to_next,
	output logic                             rollover,
	output logic                             any_active,
	output logic                             last
);
	import ttm_pkg::*;

	localparam int AW = $clog2(TIMER_SLOTS);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EXEC = 7'b0000010,
		ST_RD   = 7'b0000100,
		ST_RST2 = 7'b0001000,
		ST_SCAN = 7'b0010000,
		ST_EXW  = 7'b0100000,
		ST_RESP = 7'b1000000
	} state_t;

	state_t state_q;

	// request registers
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0]   tid_q;
	logic [PER_W-1:0]  per_q;
	logic              recin_q;
	logic              fnow_q;
	logic [TIME_W-1:0] now_q;

	// table and control state
	logic [TIMER_SLOTS-1:0] act_q;
	logic [TIMER_SLOTS-1:0] rec_q;
	logic [TIMER_SLOTS-1:0] sel_q;
	logic              fn_q;
	logic [TIME_W-1:0] prev_q;
	logic [WIN_W-1:0]  win_q;
	logic              first_q;
	logic              ro_q;
	logic              more_q;
	logic [AW-1:0]     tgt_q;
	logic [TIME_W-1:0] start_q;

	// pending result
	logic [ID_W-1:0]   p_id_q;
	logic              p_ok_q;
	logic              p_fn_q;
	logic [TIME_W-1:0] p_ttn_q;
	logic              p_ro_q;
	logic              p_last_q;

	// output register
	logic              ov_q;
	logic [ID_W-1:0]   o_id_q;
	logic              o_ok_q;
	logic              o_fn_q;
	logic [TIME_W-1:0] o_ttn_q;
	logic              o_ro_q;
	logic              o_any_q;
	logic              o_last_q;

	// memories
	logic              exp_we;
	logic [AW-1:0]     exp_wa;
	logic [TIME_W-1:0] exp_wd;
	logic [AW-1:0]     exp_ra;
	logic [TIME_W-1:0] exp_rd;
	logic              per_we;
	logic [AW-1:0]     per_wa;
	logic [AW-1:0]     per_ra;
	logic [PER_W-1:0]  per_rd;

	// scan engine
	logic              scan_start;
	logic [TIMER_SLOTS-1:0] scan_mask;
	logic              scan_due;
	logic [AW-1:0]     scan_ra;
	scan_stat_t        scan_st;
	logic [AW-1:0]     scan_cur;
	logic [AW-1:0]     scan_bid;
	logic [TIME_W-1:0] scan_bexp;

	// misc decode
	logic [6:0]        id_ext;
	logic [AW-1:0]     id_a;
	logic              idok;
	logic              free_found;
	logic [AW-1:0]     free_id;
	logic [6:0]        free_ext;
	logic [6:0]        bid_ext;
	logic              out_free;
	logic              ro_now;
	logic [TIMER_SLOTS-1:0] sel_nx;
	logic              any_now;
	logic              is_exp;

	assign id_ext   = {2'b00, tid_q};
	assign id_a     = id_ext[AW-1:0];
	assign idok     = id_ext < 7'(TIMER_SLOTS);
	assign free_ext = 7'(free_id);
	assign bid_ext  = 7'(scan_bid);
	assign out_free = !ov_q || rsp_ready;
	assign is_exp   = (kind_q == K_EXPIRE);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_id    = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_found = 1'b1;
				free_id    = AW'(i);
			end
		end
	end

	// backward jump beyond the window
	assign ro_now = (now_q < prev_q) &&
		({1'b0, prev_q} > ({1'b0, now_q} + {38'b0, win_q}));

	// selection after removing the emitted slot
	always_comb begin
		sel_nx = sel_q;
		sel_nx[scan_bid] = 1'b0;
	end

	// armed after the request: one-shot timers still selected drop out
	assign any_now = |(act_q & ~(sel_q & ~rec_q));

	// scan control
	assign scan_mask = (is_exp && !first_q) ? sel_q : act_q;
	assign scan_due  = is_exp && first_q && !ro_q;

	always_comb begin
		scan_start = 1'b0;
		case (state_q)
			ST_EXEC: begin
				if (kind_q == K_ADD) begin
					scan_start = free_found && !fn_q;
				end else if (kind_q == K_QUERY || kind_q == K_EXPIRE) begin
					scan_start = |act_q;
				end
			end
			ST_RST2: scan_start = !fn_q;
			ST_RESP: scan_start = more_q && out_free;
			default: scan_start = 1'b0;
		endcase
	end

	// memory port selection
	assign exp_ra = (state_q == ST_SCAN) ? scan_ra : id_a;
	assign per_ra = (state_q == ST_SCAN) ? scan_bid : id_a;

	always_comb begin
		exp_we = 1'b0;
		exp_wa = id_a;
		exp_wd = now_q + {32'b0, per_q};
		per_we = 1'b0;
		per_wa = id_a;
		case (state_q)
			ST_EXEC: begin
				if (kind_q == K_ADD && free_found) begin
					exp_we = 1'b1;
					exp_wa = free_id;
					per_we = 1'b1;
					per_wa = free_id;
				end
			end
			ST_RD: begin
				if (kind_q == K_REFRESH) begin
					exp_we = 1'b1;
					exp_wd = now_q + {32'b0, per_rd};
				end
			end
			ST_RST2: begin
				exp_we = 1'b1;
				exp_wd = start_q + {32'b0, per_q};
				per_we = 1'b1;
			end
			ST_EXW: begin
				exp_wa = scan_bid;
				exp_wd = now_q + {32'b0, per_rd};
				exp_we = rec_q[scan_bid];
			end
			default: exp_we = 1'b0;
		endcase
	end

	ttm_ram #(.WIDTH(TIME_W), .DEPTH(TIMER_SLOTS)) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (exp_wa),
		.wdata (exp_wd),
		.raddr (exp_ra),
		.rdata (exp_rd)
	);

	ttm_ram #(.WIDTH(PER_W), .DEPTH(TIMER_SLOTS)) u_per_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (per_wa),
		.wdata (per_q),
		.raddr (per_ra),
		.rdata (per_rd)
	);

	ttm_scan #(.SLOTS(TIMER_SLOTS), .AW(AW)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.mask     (scan_mask),
		.due_only (scan_due),
		.lim      (now_q),
		.rdata    (exp_rd),
		.raddr    (scan_ra),
		.stat     (scan_st),
		.cur_id   (scan_cur),
		.best_id  (scan_bid),
		.best_exp (scan_bexp)
	);

	// recurring flags, written on add
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && kind_q == K_ADD && free_found) begin
			rec_q[free_id] <= recin_q;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_q  <= kind;
			tid_q   <= timer_id;
			per_q   <= period_ms;
			recin_q <= recurring;
			fnow_q  <= restart_now;
			now_q   <= now_ms;
		end
		if (state_q == ST_RD) begin
			start_q <= fnow_q ? now_q : (exp_rd - {32'b0, per_rd});
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW) begin
			win_q <= pwdata[WIN_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW) ? {5'b0, win_q} : 32'b0;

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			act_q    <= '0;
			sel_q    <= '0;
			fn_q     <= 1'b0;
			prev_q   <= '0;
			first_q  <= 1'b0;
			ro_q     <= 1'b0;
			more_q   <= 1'b0;
			tgt_q    <= '0;
			p_id_q   <= '0;
			p_ok_q   <= 1'b0;
			p_fn_q   <= 1'b0;
			p_ttn_q  <= '0;
			p_ro_q   <= 1'b0;
			p_last_q <= 1'b1;
			ov_q     <= 1'b0;
			o_id_q   <= '0;
			o_ok_q   <= 1'b0;
			o_fn_q   <= 1'b0;
			o_ttn_q  <= '0;
			o_ro_q   <= 1'b0;
			o_any_q  <= 1'b0;
			o_last_q <= 1'b0;
		end else begin
			if (ov_q && rsp_ready && state_q != ST_RESP) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				// first decode of the request
				ST_EXEC: begin
					p_id_q   <= '0;
					p_ok_q   <= 1'b0;
					p_fn_q   <= 1'b0;
					p_ttn_q  <= '0;
					p_ro_q   <= 1'b0;
					p_last_q <= 1'b1;
					more_q   <= 1'b0;
					state_q  <= ST_RESP;
					case (kind_q)
						K_ADD: begin
							if (free_found) begin
								act_q[free_id] <= 1'b1;
								p_id_q <= free_ext[ID_W-1:0];
								p_ok_q <= 1'b1;
								tgt_q  <= free_id;
								if (!fn_q) begin
									state_q <= ST_SCAN;
								end
							end
						end
						K_CANCEL: begin
							if (idok && act_q[id_a]) begin
								act_q[id_a] <= 1'b0;
								p_ok_q <= 1'b1;
							end
						end
						K_REFRESH: begin
							if (idok && act_q[id_a]) begin
								state_q <= ST_RD;
							end
						end
						K_RESET: begin
							if (idok) begin
								state_q <= ST_RD;
							end
						end
						K_QUERY: begin
							fn_q   <= 1'b0;
							p_ok_q <= 1'b1;
							if (|act_q) begin
								state_q <= ST_SCAN;
							end else begin
								p_ttn_q <= TIME_ALL_ONES;
							end
						end
						K_EXPIRE: begin
							if (|act_q) begin
								ro_q    <= ro_now;
								prev_q  <= now_q;
								first_q <= 1'b1;
								sel_q   <= '0;
								state_q <= ST_SCAN;
							end
						end
						default: state_q <= ST_RESP;
					endcase
				end
				// period and expiry of the addressed slot are back
				ST_RD: begin
					state_q <= ST_RESP;
					if (kind_q == K_REFRESH) begin
						p_ok_q <= 1'b1;
					end else if (per_q == per_rd && !fnow_q) begin
						p_ok_q <= 1'b1;
					end else if (act_q[id_a]) begin
						state_q <= ST_RST2;
					end
				end
				// write the new period and expiry
				ST_RST2: begin
					p_ok_q <= 1'b1;
					tgt_q  <= id_a;
					state_q <= fn_q ? ST_RESP : ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_st.hit && is_exp && first_q) begin
						sel_q[scan_cur] <= 1'b1;
					end
					if (scan_st.done) begin
						state_q <= ST_RESP;
						case (kind_q)
							K_QUERY: begin
								p_ttn_q <= (now_q >= scan_bexp) ? '0 : (scan_bexp - now_q);
							end
							K_EXPIRE: begin
								first_q <= 1'b0;
								p_ro_q  <= ro_q;
								if (scan_st.found) begin
									state_q <= ST_EXW;
								end else begin
									p_ok_q   <= 1'b0;
									p_id_q   <= '0;
									p_last_q <= 1'b1;
									more_q   <= 1'b0;
								end
							end
							default: begin
								if (scan_bid == tgt_q) begin
									p_fn_q <= 1'b1;
									fn_q   <= 1'b1;
								end
							end
						endcase
					end
				end
				// re-arm or disarm the timer just found
				ST_EXW: begin
					sel_q <= sel_nx;
					if (!rec_q[scan_bid]) begin
						act_q[scan_bid] <= 1'b0;
					end
					p_id_q   <= bid_ext[ID_W-1:0];
					p_ok_q   <= 1'b1;
					p_last_q <= (sel_nx == '0);
					more_q   <= (sel_nx != '0);
					state_q  <= ST_RESP;
				end
				// hand the result to the output register
				ST_RESP: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_id_q   <= p_id_q;
						o_ok_q   <= p_ok_q;
						o_fn_q   <= p_fn_q;
						o_ttn_q  <= p_ttn_q;
						o_ro_q   <= p_ro_q;
						o_any_q  <= any_now;
						o_last_q <= p_last_q;
						state_q  <= more_q ? ST_SCAN : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready    = (state_q == ST_IDLE);
	assign rsp_valid    = ov_q;
	assign result_id    = o_id_q;
	assign ok           = o_ok_q;
	assign front_notice = o_fn_q;
	assign time_to_next = o_ttn_q;
	assign rollover     = o_ro_q;
	assign any_active   = o_any_q;
	assign last         = o_last_q;

`ifndef SYNTH
	// scan completes only while the sequencer waits for it
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		scan_st.done |-> state_q == ST_SCAN)
		else $error("scan finished outside scan state");

	// expire selection never holds an unarmed slot
	a_sel_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_q & ~act_q) == '0)
		else $error("selected slot not armed");

	// an accepted request goes straight to decode
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q == ST_EXEC)
		else $error("accepted request not decoded");

	// sequencer state stays one-hot
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");
`endif
endmodule
`default_nettype wire

@@ sim/timer_table_manager_test.sv @@
`timescale 1ns / 1ps
module timer_table_manager_test;
	import ttm_pkg::*;

	localparam int SLOTS = 32;
	localparam logic [KIND_W-1:0] K_UNUSED_A = 3'd6;
	localparam logic [KIND_W-1:0] K_UNUSED_B = 3'd7;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 70;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0] id;
		logic [PER_W-1:0] per;
		logic rec;
		logic fnow;
		logic [TIME_W-1:0] now;
	} timer_req_t;

	typedef struct {
		logic [ID_W-1:0] id;
		logic ok;
		logic fn;
		logic [TIME_W-1:0] ttn;
		logic ro;
		logic any;
		logic last;
	} timer_rsp_t;

	// timer table prediction and result comparison
	class timer_table_model;
		logic [TIME_W-1:0] expiry[SLOTS];
		logic [PER_W-1:0] period[SLOTS];
		bit armed[SLOTS];
		bit repeats[SLOTS];
		bit written[SLOTS];
		logic [TIME_W-1:0] last_now;
		bit notified;
		logic [WIN_W-1:0] window;
		timer_rsp_t expected_results[$];
		int errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				armed[i] = 0;
				written[i] = 0;
			end
			last_now = '0;
			notified = 0;
			window = WIN_RESET;
			errors = 0;
		endfunction

		function bit earlier(int a, int b);
			if (expiry[a] != expiry[b])
				return expiry[a] < expiry[b];
			return a < b;
		endfunction

		function int earliest_of(bit sel[SLOTS]);
			int best;
			best = SLOTS;
			for (int i = 0; i < SLOTS; i++)
				if (sel[i] && (best == SLOTS || earlier(i, best)))
					best = i;
			return best;
		endfunction

		function bit front_notice_for(int s);
			for (int j = 0; j < SLOTS; j++)
				if (j != s && armed[j] && earlier(j, s))
					return 0;
			if (notified)
				return 0;
			notified = 1;
			return 1;
		endfunction

		function bit any_armed();
			foreach (armed[i])
				if (armed[i])
					return 1;
			return 0;
		endfunction

		function void note_request(timer_req_t r);
			timer_rsp_t res[$];
			timer_rsp_t one;
			bit sel[SLOTS];
			bit ro;
			int e;
			logic [TIME_W-1:0] start;
			one = '{id: '0, ok: 0, fn: 0, ttn: '0, ro: 0, any: 0, last: 0};
			case (r.kind)
				K_ADD: begin
					e = SLOTS;
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!armed[i])
							e = i;
					if (e < SLOTS) begin
						period[e] = r.per;
						repeats[e] = r.rec;
						expiry[e] = r.now + TIME_W'(r.per);
						armed[e] = 1;
						written[e] = 1;
						one.id = ID_W'(e);
						one.ok = 1;
						one.fn = front_notice_for(e);
					end
				end
				K_CANCEL: begin
					if (armed[r.id]) begin
						armed[r.id] = 0;
						one.ok = 1;
					end
				end
				K_REFRESH: begin
					if (armed[r.id]) begin
						expiry[r.id] = r.now + TIME_W'(period[r.id]);
						one.ok = 1;
					end
				end
				K_RESET: begin
					if (r.per == period[r.id] && !r.fnow) begin
						one.ok = 1;
					end else if (armed[r.id]) begin
						start = r.fnow ? r.now : expiry[r.id] - TIME_W'(period[r.id]);
						period[r.id] = r.per;
						expiry[r.id] = start + TIME_W'(r.per);
						one.ok = 1;
						one.fn = front_notice_for(r.id);
					end
				end
				K_QUERY: begin
					e = earliest_of(armed);
					notified = 0;
					one.ok = 1;
					one.ttn = TIME_ALL_ONES;
					if (e < SLOTS)
						one.ttn = (r.now >= expiry[e]) ? '0 : expiry[e] - r.now;
				end
				K_EXPIRE: begin
					if (any_armed()) begin
						ro = r.now < last_now && (last_now - r.now) > TIME_W'(window);
						last_now = r.now;
						for (int i = 0; i < SLOTS; i++)
							sel[i] = armed[i] && (ro || expiry[i] <= r.now);
						one.ro = ro;
						e = earliest_of(sel);
						while (e < SLOTS) begin
							sel[e] = 0;
							one.id = ID_W'(e);
							one.ok = 1;
							res = {res, one};
							if (repeats[e])
								expiry[e] = r.now + TIME_W'(period[e]);
							else
								armed[e] = 0;
							e = earliest_of(sel);
						end
						one.id = '0;
						one.ok = 0;
					end
				end
				default: ;
			endcase
			if (res.size() == 0)
				res = {res, one};
			foreach (res[k]) begin
				res[k].any = any_armed();
				res[k].last = (k == res.size() - 1);
				expected_results = {expected_results, res[k]};
			end
		endfunction

		function void check_result(timer_rsp_t got);
			timer_rsp_t want;
			if (expected_results.size() == 0) begin
				$error("result with nothing outstanding: id %0d ok %0d", got.id, got.ok);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.id !== want.id) begin
				$error("result_id expected %0d got %0d", want.id, got.id);
				errors++;
			end
			if (got.ok !== want.ok) begin
				$error("ok expected %0d got %0d", want.ok, got.ok);
				errors++;
			end
			if (got.fn !== want.fn) begin
				$error("front_notice expected %0d got %0d", want.fn, got.fn);
				errors++;
			end
			if (got.ttn !== want.ttn) begin
				$error("time_to_next expected %h got %h", want.ttn, got.ttn);
				errors++;
			end
			if (got.ro !== want.ro) begin
				$error("rollover expected %0d got %0d", want.ro, got.ro);
				errors++;
			end
			if (got.any !== want.any) begin
				$error("any_active expected %0d got %0d", want.any, got.any);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0d got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 0;
	logic req_ready;
	logic [KIND_W-1:0] kind = '0;
	logic [ID_W-1:0] timer_id = '0;
	logic [PER_W-1:0] period_ms = '0;
	logic recurring = 0, restart_now = 0;
	logic [TIME_W-1:0] now_ms = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	logic [ID_W-1:0] result_id;
	logic ok, front_notice, rollover, any_active, last;
	logic [TIME_W-1:0] time_to_next;

	timer_table_model model = new();
	logic [TIME_W-1:0] clock_ms;
	int burst_left = 0;
	bit hold_go = 0;
	bit hold_taken = 0;
	int idle_cycles = 0;
	int cfg_errors = 0;

	timer_table_manager #(.TIMER_SLOTS(SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .kind(kind),
		.timer_id(timer_id), .period_ms(period_ms), .recurring(recurring),
		.restart_now(restart_now), .now_ms(now_ms),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .result_id(result_id),
		.ok(ok), .front_notice(front_notice), .time_to_next(time_to_next),
		.rollover(rollover), .any_active(any_active), .last(last)
	);

	// clock
	always #1 clk = ~clk;

	// receiver: own stall pattern plus one long hold-off
	always @(negedge clk) begin
		int hold_cnt;
		int mode;
		if (hold_go && !hold_taken) begin
			hold_taken = 1;
			hold_cnt = HOLD_CYCLES;
		end
		if ($urandom_range(0, 63) == 0)
			mode = $urandom_range(0, 3);
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ready = 0;
		end else begin
			case (mode)
				0: rsp_ready = 1;
				1: rsp_ready = ($urandom_range(0, 3) != 0);
				2: rsp_ready = ($urandom_range(0, 3) == 0);
				default: rsp_ready = ($urandom_range(0, 7) < 6);
			endcase
		end
	end

	// result check and idle watchdog
	always @(posedge clk) begin
		timer_rsp_t got;
		if (rsp_valid && rsp_ready) begin
			got = '{id: result_id, ok: ok, fn: front_notice, ttn: time_to_next,
				ro: rollover, any: any_active, last: last};
			model.check_result(got);
		end
		if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || psel || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one request, then a gap when the burst runs out
	task automatic send_request(timer_req_t r);
		@(negedge clk);
		kind = r.kind;
		timer_id = r.id;
		period_ms = r.per;
		recurring = r.rec;
		restart_now = r.fnow;
		now_ms = r.now;
		req_valid = 1;
		do
			@(posedge clk);
		while (!req_ready);
		model.note_request(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			@(negedge clk);
			req_valid = 0;
			repeat ($urandom_range(0, 8))
				@(negedge clk);
		end
	endtask

	task automatic request(logic [KIND_W-1:0] k, int id, logic [PER_W-1:0] per,
		bit rec, bit fnow);
		timer_req_t r;
		r = '{kind: k, id: ID_W'(id), per: per, rec: rec, fnow: fnow, now: clock_ms};
		send_request(r);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid = 0;
		while (model.expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 20)
			@(posedge clk);
	endtask

	task automatic write_window(logic [WIN_W-1:0] w);
		wait_idle();
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		paddr = 3'(4 * REG_WINDOW);
		pwdata = 32'(w);
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		model.window = w;
		@(negedge clk);
		pwrite = 0;
		penable = 0;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		if (prdata[WIN_W-1:0] !== w) begin
			$error("rollover_window_ms expected %0d got %0d", w, prdata[WIN_W-1:0]);
			cfg_errors++;
		end
		@(negedge clk);
		psel = 0;
		penable = 0;
	endtask

	function automatic logic [PER_W-1:0] pick_period();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return PER_W'($urandom_range(0, 300));
		if (p < 85)
			return PER_W'($urandom);
		if (p < 95)
			return '0;
		return '1;
	endfunction

	function automatic int pick_written();
		int s;
		for (int t = 0; t < 16; t++) begin
			s = $urandom_range(0, SLOTS - 1);
			if (model.written[s])
				return s;
		end
		for (s = 0; s < SLOTS; s++)
			if (model.written[s])
				return s;
		return -1;
	endfunction

	// one random request with its time moved on
	task automatic random_request();
		int p;
		int s;
		p = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			clock_ms = clock_ms - TIME_W'($urandom_range(0, 100000000));
		else
			clock_ms = clock_ms + TIME_W'($urandom_range(0, 60));
		s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SLOTS - 1) : pick_written();
		if (p < 25) begin
			request(K_ADD, $urandom_range(0, SLOTS - 1), pick_period(), $urandom_range(0, 1),
				$urandom_range(0, 1));
		end else if (p < 35 && s >= 0) begin
			request(K_CANCEL, s, $urandom, 0, 0);
		end else if (p < 45 && s >= 0) begin
			request(K_REFRESH, s, $urandom, 0, 0);
		end else if (p < 60) begin
			// reset only on slots that have been written
			s = pick_written();
			if (s >= 0)
				request(K_RESET, s, ($urandom_range(0, 2) == 0) ? model.period[s] : pick_period(),
					0, $urandom_range(0, 1));
			else
				request(K_QUERY, 0, $urandom, 0, 0);
		end else if (p < 70) begin
			request(K_QUERY, $urandom_range(0, SLOTS - 1), $urandom, 0, 0);
		end else if (p < 95) begin
			request(K_EXPIRE, $urandom_range(0, SLOTS - 1), $urandom, 0, 0);
		end else begin
			request(($urandom_range(0, 1) != 0) ? K_UNUSED_A : K_UNUSED_B,
				$urandom_range(0, SLOTS - 1), $urandom, 1, 1);
		end
	endtask

	// fill the table, overflow it, then expire everything at once
	task automatic fill_and_drain(bit by_rollover);
		for (int i = 0; i <= SLOTS; i++)
			request(K_ADD, 0, pick_period(), $urandom_range(0, 1), 0);
		if (by_rollover) begin
			request(K_EXPIRE, 0, 0, 0, 0);
			clock_ms = clock_ms - TIME_W'(model.window) - TIME_W'($urandom_range(1, 1000));
		end else begin
			clock_ms = clock_ms + 64'h2_0000_0000;
		end
		request(K_EXPIRE, 0, 0, 0, 0);
	endtask

	initial begin
		int n;
		clock_ms = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, notices, resets, bad kinds
		request(K_QUERY, 0, 0, 0, 0);
		request(K_EXPIRE, 0, 0, 0, 0);
		request(K_ADD, 0, '0, 0, 0);
		request(K_ADD, 0, '1, 1, 1);
		request(K_ADD, 0, 32'd5, 1, 0);
		request(K_QUERY, 31, '1, 1, 1);
		request(K_RESET, 1, '1, 0, 0);
		request(K_RESET, 1, 32'd3, 0, 1);
		clock_ms = clock_ms + 2;
		request(K_REFRESH, 0, 0, 0, 0);
		request(K_RESET, 2, 32'd1, 0, 0);
		request(K_CANCEL, 0, 0, 0, 0);
		request(K_CANCEL, 0, 0, 0, 0);
		request(K_REFRESH, 0, 0, 0, 0);
		request(K_RESET, 0, '0, 0, 0);
		request(K_RESET, 0, 32'd7, 0, 1);
		request(K_CANCEL, 31, 0, 0, 0);
		request(K_REFRESH, 31, 0, 0, 0);
		request(K_UNUSED_A, 0, 0, 0, 0);
		request(K_UNUSED_B, 31, '1, 1, 1);
		clock_ms = clock_ms + 10;
		request(K_EXPIRE, 0, 0, 0, 0);
		request(K_QUERY, 0, 0, 0, 0);
		clock_ms = 64'hFFFF_FFFF_FFFF_FF00;
		request(K_ADD, 0, 32'h200, 0, 0);
		request(K_QUERY, 0, 0, 0, 0);

		// random phases over several windows, zero and one day among them
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_window('0);
				1: write_window(WIN_W'(86400000));
				2: write_window(WIN_W'($urandom_range(1, 86400000)));
				3: write_window(WIN_RESET);
				default: write_window(WIN_W'($urandom_range(0, 1000)));
			endcase
			clock_ms = {$urandom, $urandom};
			if (ph < 2)
				fill_and_drain(ph % 2);
			if (ph == 2)
				hold_go = 1;
			n = RANDOM_ITEMS / 5;
			for (int i = 0; i < n; i++)
				random_request();
		end

		wait_idle();
		if (model.errors == 0 && cfg_errors == 0 && model.expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/ttm_pkg.sv
hdl/ttm_ram.sv
hdl/ttm_scan.sv
hdl/timer_table_manager.sv
sim/timer_table_manager_test.sv
